// ===== rtl/core/piecewise_linear_lookup_top_assert.svh =====
// Assertion macros shared by the piecewise-linear lookup RTL.
// Standalone header; no dependencies. Bodies vanish when SYNTHESIS is defined.
`ifndef PIECEWISE_LINEAR_LOOKUP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pll: same-cycle check failed");
// next-cycle implication
`define PLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pll: next-cycle check failed");
`else
`define PLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pll_pkg.sv =====
// Package for the piecewise-linear lookup: widths, request/result types,
// controller states and controller/datapath command and status structs. No dependencies.
package pll_pkg;

    localparam int INPUT_BITS        = 16;
    localparam int OUTPUT_BITS       = 16;
    localparam int TABLE_DEPTH_DEF   = 32;
    localparam int SLOT_BITS         = 5;
    localparam int ENTRIES_BITS      = 6;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;
    localparam int REG_INDEX_BITS    = APB_ADDR_BITS - 2;
    localparam int DIV_CNT_BITS      = $clog2(OUTPUT_BITS);

    localparam logic [ENTRIES_BITS-1:0]   ENTRIES_RESET      = ENTRIES_BITS'(32);
    localparam logic [REG_INDEX_BITS-1:0] REG_ENTRIES_IN_USE = REG_INDEX_BITS'(0);

    typedef enum logic {
        OP_EVALUATE = 1'b0,
        OP_WRITE    = 1'b1
    } t_operation;

    typedef struct packed {
        t_operation                     operation;
        logic [SLOT_BITS-1:0]           entry_slot;
        logic [INPUT_BITS-1:0]          entry_breakpoint;
        logic signed [OUTPUT_BITS-1:0]  entry_level;
        logic [INPUT_BITS-1:0]          query_value;
    } t_request;

    typedef struct packed {
        logic signed [OUTPUT_BITS-1:0]  interpolated_level;
        logic                           was_clamped;
        logic                           exact_hit;
    } t_result;

    // one table row: breakpoint and its level
    typedef struct packed {
        logic [INPUT_BITS-1:0]          breakpoint;
        logic signed [OUTPUT_BITS-1:0]  level;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CLAMP,
        S_SCAN,
        S_DECIDE,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FIX
    } t_state;

    typedef struct packed {
        logic write_entry;
        logic load_eval;
        logic cap_lo;
        logic clamp;
        logic scan;
        logic mul;
        logic div_init;
        logic div_step;
        logic emit_direct;
        logic emit_interp;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic direct;
        logic div_last;
    } t_dp_status;

endpackage

// ===== rtl/core/pll_ctrl.sv =====
// Sequencer for the piecewise-linear lookup: steps the datapath through
// read, clamp, scan, multiply and divide. Depends on pll_pkg and the assert header.
`include "piecewise_linear_lookup_top_assert.svh"

module pll_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  pll_pkg::t_operation   i_operation,
    input  pll_pkg::t_dp_status   i_status,
    output pll_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);
    import pll_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_accept) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.write_entry = 1'b1;
                    end else begin
                        o_cmd.load_eval = 1'b1;
                        n_state         = S_RD_LO;
                    end
                end
            end
            S_RD_LO: begin
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.direct) begin
                    o_cmd.emit_direct = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.emit_interp = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PLL_ASSERT_SAME(a_accept_when_idle, i_clk, i_rst_n, i_accept, r_state == S_IDLE)
    `PLL_ASSERT_SAME(a_one_phase, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.emit_direct, o_cmd.emit_interp, o_cmd.mul, o_cmd.div_step}))
    `PLL_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, r_state == S_DIV, r_state == S_DIV || r_state == S_FIX)

endmodule

// ===== rtl/core/pll_datapath.sv =====
// Datapath for the piecewise-linear lookup: table memory, clamp, linear scan,
// one multiply and a restoring divider. Depends on pll_pkg and the assert header.
`include "piecewise_linear_lookup_top_assert.svh"

module pll_datapath #(
    parameter int TABLE_DEPTH = pll_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pll_pkg::t_dp_cmd                  i_cmd,
    input  pll_pkg::t_request                 i_request,
    input  logic [pll_pkg::ENTRIES_BITS-1:0]  i_entries,
    output pll_pkg::t_dp_status               o_status,
    output pll_pkg::t_result                  o_result,
    output logic                              o_result_strobe
);
    import pll_pkg::*;

    localparam int IB     = INPUT_BITS;
    localparam int OB     = OUTPUT_BITS;
    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int PROD_W = IB + OB + 2;

    // table memory with registered read
    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rd;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic              wr_ok;

    // request and search state
    logic [IB-1:0]     r_query;
    logic [IW-1:0]     r_last;
    logic [IW-1:0]     n_last;
    logic [IB-1:0]     r_lo;
    logic [IB-1:0]     r_v;
    logic              r_clamped;
    logic [IW-1:0]     r_idx;
    t_entry            r_prev;
    logic [IB-1:0]     r_x0;
    logic [IB-1:0]     r_x1;
    logic signed [OB-1:0] r_y0;
    logic signed [OB-1:0] r_y1;
    logic              r_exact;
    logic              r_first;
    logic [IB-1:0]     lifted;
    logic [IB-1:0]     clamped_v;
    logic              hit;

    // arithmetic
    logic [IB-1:0]        diff_x;
    logic signed [OB:0]   diff_y;
    logic signed [IB:0]   mul_a;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0]    w_mag;
    logic [IB-1:0]        r_div;
    logic [IB-1:0]        r_rem;
    logic [OB-1:0]        r_low;
    logic                 r_neg;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [IB:0]          rem_sh;
    logic [IB:0]          rem_sub;
    logic                 rem_ge;
    logic signed [OB:0]   w_q;
    logic signed [OB:0]   w_adj;
    logic [OB:0]          w_sum;

    t_result           r_res;
    logic              r_res_vld;

    // clamp the configured count to the table and form the last index
    always_comb begin
        if (i_entries < ENTRIES_BITS'(2)) begin
            n_last = IW'(1);
        end else if (int'(i_entries) > TABLE_DEPTH) begin
            n_last = IW'(TABLE_DEPTH - 1);
        end else begin
            n_last = IW'(i_entries - 1'b1);
        end
    end

    // read address: slot 0, then the last slot, then the scan
    always_comb begin
        wr_addr = IW'(i_request.entry_slot);
        wr_ok   = int'(i_request.entry_slot) < TABLE_DEPTH;
        if (i_cmd.scan) begin
            rd_addr = IW'(r_idx + 1'b1);
        end else if (i_cmd.cap_lo) begin
            rd_addr = r_last;
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && wr_ok) begin
            r_mem[wr_addr] <= '{breakpoint: i_request.entry_breakpoint,
                                level:      i_request.entry_level};
        end
        r_rd <= r_mem[rd_addr];
    end

    // clamp: raise to first breakpoint, then lower to the last
    always_comb begin
        lifted    = (r_query < r_lo) ? r_lo : r_query;
        clamped_v = (lifted > r_rd.breakpoint) ? r_rd.breakpoint : lifted;
        hit       = r_rd.breakpoint >= r_v;
    end

    // multiply operands
    always_comb begin
        diff_x = r_v - r_x0;
        diff_y = {r_y1[OB-1], r_y1} - {r_y0[OB-1], r_y0};
        mul_a  = signed'({1'b0, diff_x});
        w_prod = mul_a * diff_y;
        w_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : r_prod;
    end

    // restoring divider step, one quotient bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_low[OB-1]};
        rem_ge  = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // apply sign and add the left level
    always_comb begin
        w_q   = signed'({1'b0, r_low});
        w_adj = r_neg ? -w_q : w_q;
        w_sum = {r_y0[OB-1], r_y0} + w_adj;
    end

    // search and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_eval) begin
            r_query <= i_request.query_value;
            r_last  <= n_last;
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_rd.breakpoint;
        end
        if (i_cmd.clamp) begin
            r_v       <= clamped_v;
            r_clamped <= clamped_v != r_query;
            r_idx     <= '0;
        end
        if (i_cmd.scan) begin
            if (o_status.scan_done) begin
                r_x1    <= r_rd.breakpoint;
                r_y1    <= r_rd.level;
                r_x0    <= r_prev.breakpoint;
                r_y0    <= r_prev.level;
                r_exact <= r_rd.breakpoint == r_v;
                r_first <= r_idx == '0;
            end else begin
                r_prev <= r_rd;
                r_idx  <= IW'(r_idx + 1'b1);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_div  <= r_x1 - r_x0;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_prod[PROD_W-1];
            r_rem <= w_mag[IB+OB-1:OB];
            r_low <= w_mag[OB-1:0];
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[IB-1:0] : rem_sh[IB-1:0];
            r_low <= {r_low[OB-2:0], rem_ge};
            r_cnt <= DIV_CNT_BITS'(r_cnt + 1'b1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_direct) begin
            r_res.interpolated_level <= r_y1;
        end else if (i_cmd.emit_interp) begin
            r_res.interpolated_level <= w_sum[OB-1:0];
        end
        if (i_cmd.emit_direct || i_cmd.emit_interp) begin
            r_res.was_clamped <= r_clamped;
            r_res.exact_hit   <= r_exact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.emit_direct || i_cmd.emit_interp;
        end
    end

    always_comb begin
        o_status.scan_done = hit || (r_idx == r_last);
        o_status.direct    = r_exact || r_first || !((r_x1 > r_x0) && (r_v >= r_x0));
        o_status.div_last  = r_cnt == DIV_CNT_BITS'(OB - 1);
    end

    assign o_result        = r_res;
    assign o_result_strobe = r_res_vld;

    `PLL_ASSERT_SAME(a_scan_in_range, i_clk, i_rst_n, i_cmd.scan, r_idx <= r_last)
    `PLL_ASSERT_SAME(a_rem_below_div, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_div)
    `PLL_ASSERT_NEXT(a_clamp_flag, i_clk, i_rst_n, i_cmd.clamp, r_clamped == (r_v != r_query))

endmodule

// ===== rtl/core/piecewise_linear_lookup_top.sv =====
// Top level of the piecewise-linear lookup: APB register, request handshake,
// controller and datapath. Depends on pll_pkg, pll_ctrl and pll_datapath.
//
//   channel   direction  handshake                     payload
//   request   in         start high while busy low     i_request (t_request)
//   result    out        o_result_strobe, one cycle    o_result (t_result)
//   config    in         APB write, pready tied high   pwdata (entries_in_use)
//
// A write request is written to the table when it is accepted; busy stays low.
// An evaluation reads the first and last rows, clamps, then scans one row a cycle from the
// single read port, over at most entries_in_use rows (clamped to 2..TABLE_DEPTH); a stored
// level is returned directly, else it multiplies and the divider adds one bit a cycle.
// Busy falls in the strobe cycle, so the next request may be taken then; no stalls.
// Reset is synchronous; the table keeps its contents and is valid only once written.

module piecewise_linear_lookup_top #(
    parameter int TABLE_DEPTH = pll_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pll_pkg::t_request                   i_request,
    output pll_pkg::t_result                    o_result,
    output logic                                o_result_strobe,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pll_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [pll_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [pll_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import pll_pkg::*;

    logic [ENTRIES_BITS-1:0] r_entries;
    logic                    accept;
    logic                    reg_hit;
    t_dp_cmd                 cmd;
    t_dp_status              status;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_BITS-1:2] == REG_ENTRIES_IN_USE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_entries <= pwdata[ENTRIES_BITS-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_BITS'(r_entries) : '0;

    // request handshake
    assign accept = start && !busy;

    pll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_request.operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    pll_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_request       (i_request),
        .i_entries       (r_entries),
        .o_status        (status),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

// ===== dv/piecewise_linear_lookup_top_tb.sv =====
// Self-checking testbench for piecewise_linear_lookup_top: table loads, evaluations and
// entry-count settings, each result checked against an in-bench interpolation predictor.
// Depends on pll_pkg and the piecewise_linear_lookup_top RTL.
`timescale 1ns / 1ps

module piecewise_linear_lookup_top_tb;
    import pll_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_ENTRIES = {REG_ENTRIES_IN_USE, 2'b00};

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    t_request                   i_request;
    t_result                    o_result;
    logic                       o_result_strobe;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_BITS-1:0]   paddr;
    logic [APB_DATA_BITS-1:0]   pwdata;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    // predictor copy of the table and the entry count
    logic [INPUT_BITS-1:0]          bp_table [DEPTH];
    logic signed [OUTPUT_BITS-1:0]  lvl_table [DEPTH];
    logic [ENTRIES_BITS-1:0]        entries_reg;
    t_result                        level_queue [$];

    int errors = 0;
    int n_evals = 0;
    int n_writes = 0;
    int n_clamped = 0;
    int n_exact = 0;
    int n_settings = 0;
    int idle_pct = 0;

    piecewise_linear_lookup_top u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_request, .o_result, .o_result_strobe,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // entry count as the block applies it
    function automatic int unsigned rows_in_use();
        int unsigned n;
        n = entries_reg;
        if (n < 2) n = 2;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    // clamp, search for the first breakpoint not below the value, then interpolate
    function automatic t_result predict_lookup(logic [INPUT_BITS-1:0] query);
        int unsigned n, found, i;
        logic [INPUT_BITS-1:0] v;
        longint y0, y1, span, level;
        bit hit, searching;
        t_result r;
        n = rows_in_use();
        v = query;
        if (v < bp_table[0]) v = bp_table[0];
        if (v > bp_table[n-1]) v = bp_table[n-1];
        found = n - 1;
        searching = 1'b1;
        for (i = 0; i < n; i++) begin
            if (searching && bp_table[i] >= v) begin
                found = i;
                searching = 1'b0;
            end
        end
        hit = (bp_table[found] == v);
        if (hit || found == 0) begin
            level = longint'(lvl_table[found]);
        end else begin
            y0 = longint'(lvl_table[found-1]);
            y1 = longint'(lvl_table[found]);
            span = longint'(bp_table[found]) - longint'(bp_table[found-1]);
            if (span > 0 && v >= bp_table[found-1]) begin
                // signed division truncates toward zero
                level = y0 + (longint'(v) - longint'(bp_table[found-1])) * (y1 - y0) / span;
            end else begin
                level = y1;
            end
        end
        r.interpolated_level = level[OUTPUT_BITS-1:0];
        r.was_clamped = (v != query);
        r.exact_hit = hit;
        return r;
    endfunction

    // one request: optional idle gap, then hold start until busy is low at an edge
    task automatic send_request(t_request req);
        int gap;
        logic [63:0] noise;
        t_result res;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            i_request <= noise[$bits(t_request)-1:0];
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_request <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // request taken at this edge
        if (req.operation == OP_WRITE) begin
            bp_table[req.entry_slot] = req.entry_breakpoint;
            lvl_table[req.entry_slot] = req.entry_level;
            n_writes++;
        end else begin
            res = predict_lookup(req.query_value);
            level_queue.push_back(res);
            n_evals++;
            n_clamped += res.was_clamped;
            n_exact += res.exact_hit;
        end
    endtask

    task automatic write_row(int unsigned slot, logic [INPUT_BITS-1:0] bp,
                             logic signed [OUTPUT_BITS-1:0] lvl);
        t_request req;
        req.operation = OP_WRITE;
        req.entry_slot = slot[SLOT_BITS-1:0];
        req.entry_breakpoint = bp;
        req.entry_level = lvl;
        req.query_value = INPUT_BITS'($urandom);
        send_request(req);
    endtask

    task automatic evaluate(logic [INPUT_BITS-1:0] query);
        t_request req;
        req.operation = OP_EVALUATE;
        req.entry_slot = SLOT_BITS'($urandom);
        req.entry_breakpoint = INPUT_BITS'($urandom);
        req.entry_level = OUTPUT_BITS'($urandom);
        req.query_value = query;
        send_request(req);
    endtask

    // stop issuing and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        while (level_queue.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the entry count, then a back-to-back read to check it
    task automatic program_entries(logic [ENTRIES_BITS-1:0] count);
        logic [APB_DATA_BITS-1:0] data;
        drain();
        data = $urandom;
        data[ENTRIES_BITS-1:0] = count;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ENTRIES;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        entries_reg = count;
        n_settings++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(APB_DATA_BITS-ENTRIES_BITS){1'b0}}, entries_reg}) begin
            $display("%0t: entry count read back: expected %0d, got %0d",
                     $time, entries_reg, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [OUTPUT_BITS-1:0] pick_level();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        return OUTPUT_BITS'($urandom);
    endfunction

    task automatic load_rows(int unsigned b0, int unsigned b1, int unsigned b2, int unsigned b3);
        write_row(0, INPUT_BITS'(b0), pick_level());
        write_row(1, INPUT_BITS'(b1), pick_level());
        write_row(2, INPUT_BITS'(b2), pick_level());
        write_row(3, INPUT_BITS'(b3), pick_level());
    endtask

    // query biased towards breakpoints and the clamp boundaries
    function automatic logic [INPUT_BITS-1:0] pick_query(int unsigned rows);
        int unsigned r, lo, hi;
        r = $urandom_range(99);
        lo = bp_table[0];
        hi = bp_table[rows-1];
        if (r < 25) return bp_table[$urandom_range(rows-1)];
        if (r < 35) return INPUT_BITS'((lo > 0) ? $urandom_range(0, lo - 1) : 0);
        if (r < 45) return INPUT_BITS'((hi < 65535) ? $urandom_range(hi + 1, 65535) : 65535);
        if (r < 50) return $urandom_range(1) ? 16'hffff : 16'h0000;
        if (lo <= hi) return INPUT_BITS'($urandom_range(lo, hi));
        return INPUT_BITS'($urandom);
    endfunction

    // extremes of every field on a rising ramp, then with the end rows at the outer breakpoints and swapped levels
    task automatic test_directed();
        int unsigned s;
        idle_pct = 0;
        for (s = 0; s < DEPTH; s++)
            write_row(s, INPUT_BITS'(1000 + s * 2000),
                      (s == DEPTH - 1) ? 16'sh7fff : OUTPUT_BITS'(-32768 + int'(s) * 2114));
        evaluate(16'd0);
        evaluate(16'hffff);
        evaluate(16'd1000);
        evaluate(16'd63000);
        evaluate(16'd3000);
        evaluate(16'd2000);
        evaluate(16'd1001);
        evaluate(16'd62999);
        write_row(0, 16'd0, 16'sh7fff);
        write_row(DEPTH - 1, 16'hffff, 16'sh8000);
        evaluate(16'd0);
        evaluate(16'hffff);
        evaluate(16'd500);
        evaluate(16'd32768);
        evaluate(16'd64000);
        drain();
    endtask

    // out-of-range counts act as the nearest legal one
    task automatic test_entry_counts();
        int unsigned k, rows;
        logic [ENTRIES_BITS-1:0] counts [8];
        counts = '{6'd2, 6'd0, 6'd1, 6'd3, 6'd33, 6'd63, 6'd16, 6'd32};
        for (k = 0; k < 8; k++) begin
            program_entries(counts[k]);
            rows = rows_in_use();
            evaluate(16'd0);
            evaluate(16'hffff);
            evaluate(bp_table[rows-1]);
            evaluate(INPUT_BITS'($urandom));
        end
        drain();
    endtask

    // tables that are not increasing: falling ends, repeats, a dip in the middle
    task automatic test_irregular();
        idle_pct = 27;
        program_entries(6'd4);
        // last breakpoint below the first: found at slot 0 without a match
        load_rows(50000, 10000, 30000, 20000);
        evaluate(16'd0);
        evaluate(16'd20000);
        evaluate(16'd40000);
        evaluate(16'hffff);
        // repeated breakpoints
        load_rows(1000, 5000, 5000, 9000);
        evaluate(16'd5000);
        evaluate(16'd4000);
        evaluate(16'd7000);
        load_rows(1000, 1000, 2000, 3000);
        evaluate(16'd1000);
        evaluate(16'd1500);
        // dip in the middle
        load_rows(100, 40000, 20000, 60000);
        evaluate(16'd30000);
        evaluate(16'd50000);
        drain();
    endtask

    // segments of: new entry count, fresh table rows, then a burst of evaluations with occasional row writes
    task automatic test_random(int items);
        int count, k, evals;
        int unsigned r, rows, shape, base, step_max, cur, slot;
        logic [ENTRIES_BITS-1:0] setting;
        count = 0;
        while (count < items) begin
            r = $urandom_range(99);
            if (r < 10) setting = ENTRIES_BITS'($urandom_range(0, 1));
            else if (r < 20) setting = ENTRIES_BITS'($urandom_range(33, 63));
            else if (r < 35) setting = ENTRIES_BITS'(32);
            else if (r < 55) setting = ENTRIES_BITS'($urandom_range(2, 4));
            else setting = ENTRIES_BITS'($urandom_range(2, 32));
            program_entries(setting);
            rows = rows_in_use();
            shape = $urandom_range(99);
            base = $urandom_range(0, 4000);
            step_max = (65535 - base) / rows;
            cur = base;
            for (slot = 0; slot < rows; slot++) begin
                if (shape >= 85) cur = $urandom_range(0, 65535);
                else if (slot > 0) cur += $urandom_range((shape < 70) ? 1 : 0, step_max);
                write_row(slot, INPUT_BITS'(cur), pick_level());
            end
            count += rows;
            evals = $urandom_range(10, 30);
            for (k = 0; k < evals; k++) begin
                if ($urandom_range(9) == 0)
                    write_row($urandom_range(DEPTH - 1), INPUT_BITS'($urandom),
                              OUTPUT_BITS'($urandom));
                else evaluate(pick_query(rows));
            end
            count += evals;
        end
        drain();
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && o_result_strobe !== 1'b0) begin
            if (level_queue.size() == 0) begin
                $display("%0t: unexpected result: level %0d clamped %b exact %b", $time,
                         o_result.interpolated_level, o_result.was_clamped, o_result.exact_hit);
                errors++;
            end else begin
                want = level_queue.pop_front();
                if (o_result.interpolated_level !== want.interpolated_level
                        || o_result.was_clamped !== want.was_clamped
                        || o_result.exact_hit !== want.exact_hit) begin
                    $display("%0t: expected level %0d clamped %b exact %b, got level %0d clamped %b exact %b",
                             $time, want.interpolated_level, want.was_clamped, want.exact_hit,
                             o_result.interpolated_level, o_result.was_clamped,
                             o_result.exact_hit);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int s = 0; s < DEPTH; s++) begin
            bp_table[s] = '0;
            lvl_table[s] = '0;
        end
        entries_reg = ENTRIES_RESET;
        start <= 1'b0;
        i_request <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_entry_counts();
        test_irregular();
        idle_pct = 0;
        test_random(170);
        idle_pct = 46;
        test_random(170);
        idle_pct = 27;
        test_random(160);
        drain();
        repeat (30) @(posedge i_clk);

        $display("Run covered %0d evaluations (%0d clamped, %0d exact hits) and %0d table writes",
                 n_evals, n_clamped, n_exact, n_writes);
        $display("over %0d entry-count settings at three sender idle rates.", n_settings);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== piecewise_linear_lookup_top.f =====
+incdir+rtl/core
rtl/core/pll_pkg.sv
rtl/core/pll_ctrl.sv
rtl/core/pll_datapath.sv
rtl/core/piecewise_linear_lookup_top.sv
dv/piecewise_linear_lookup_top_tb.sv
